// ===== rtl/tlsp_pkg.sv =====
// Shared types and constants for the temporal least-squares pixel filter.
// No dependencies.
`timescale 1ns / 1ps
package tlsp_pkg;
    localparam int MAX_RADIUS_DEF  = 8;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int CNT_W  = 5;
    localparam int SPOS_W = 9;
    localparam int SVAL_W = 21;
    localparam int SPV_W  = 25;
    localparam int SSQ_W  = 13;
    localparam int POS_W  = 5;
    localparam int SMP_W  = 16;
    localparam int VAL_W  = 16;
    localparam int RAD_W  = 4;

    localparam int NUM_W  = 48;
    localparam int DEN_W  = 27;
    localparam int REM_W  = 28;

    localparam logic             CFG_RADIUS    = 1'b0;
    localparam logic             CFG_MAX_VALUE = 1'b1;
    localparam logic [RAD_W-1:0] RADIUS_RST    = 4'd5;
    localparam logic [VAL_W-1:0] MAX_VALUE_RST = 16'd255;

    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [SPOS_W-1:0] spos;
        logic [SVAL_W-1:0] sval;
        logic [SPV_W-1:0]  spv;
        logic [SSQ_W-1:0]  ssq;
    } t_sums;

    typedef struct packed {
        logic pop;
        logic push;
    } t_back_ctl;

    typedef enum logic [2:0] {
        B_IDLE, B_MUL1, B_MUL2, B_MUL3, B_PREP, B_DIV, B_DONE
    } t_back_state;
endpackage

// ===== rtl/tlsp_fifo.sv =====
// Small register queue, used between front and back and for results.
// Depends on nothing.
`timescale 1ns / 1ps
module tlsp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_cnt == CW'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

// ===== rtl/tlsp_front.sv =====
// Front end: accumulates the window sums, one sample per beat.
// Depends on tlsp_pkg.
`timescale 1ns / 1ps
module tlsp_front #(
    parameter int SAMPLE_BITS = tlsp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [tlsp_pkg::SMP_W-1:0] i_sample,
    input  logic [tlsp_pkg::POS_W-1:0] i_position,
    input  logic                       i_is_last,
    output tlsp_pkg::t_sums            o_snap,
    output logic                       o_snap_push
);
    localparam logic [tlsp_pkg::SMP_W-1:0] SMASK =
        tlsp_pkg::SMP_W'((33'd1 << SAMPLE_BITS) - 33'd1);

    tlsp_pkg::t_sums r_sums, n_sums;
    logic [tlsp_pkg::SMP_W-1:0] w_smp;
    logic [20:0]                w_pv;
    logic [9:0]                 w_pp;

    assign w_smp = i_sample & SMASK;
    assign w_pv  = 21'(i_position) * 21'(w_smp);
    assign w_pp  = 10'(i_position) * 10'(i_position);

    always_comb begin
        n_sums.cnt  = r_sums.cnt + 1'b1;
        n_sums.spos = r_sums.spos + tlsp_pkg::SPOS_W'(i_position);
        n_sums.sval = r_sums.sval + tlsp_pkg::SVAL_W'(w_smp);
        n_sums.spv  = r_sums.spv + tlsp_pkg::SPV_W'(w_pv);
        n_sums.ssq  = r_sums.ssq + tlsp_pkg::SSQ_W'(w_pp);
    end

    assign o_snap      = n_sums;
    assign o_snap_push = i_accept && i_is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sums <= '0;
        end else if (i_accept) begin
            r_sums <= i_is_last ? '0 : n_sums;
        end
    end
endmodule

// ===== rtl/tlsp_back.sv =====
// Back end: least-squares fit at the centre, rounding divider and clamp.
// Depends on tlsp_pkg.
`timescale 1ns / 1ps
module tlsp_back #(
    parameter int MAX_RADIUS = tlsp_pkg::MAX_RADIUS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tlsp_pkg::t_sums            i_sums,
    input  logic                       i_q_empty,
    input  logic [tlsp_pkg::RAD_W-1:0] i_radius,
    input  logic [tlsp_pkg::VAL_W-1:0] i_max_value,
    input  logic                       i_out_full,
    output tlsp_pkg::t_back_ctl        o_ctl,
    output logic [tlsp_pkg::VAL_W-1:0] o_value
);
    localparam int RW = $clog2(MAX_RADIUS + 1);
    localparam int NRW = tlsp_pkg::CNT_W + RW;
    localparam int TW = NRW + 2;
    localparam int NW = tlsp_pkg::NUM_W;
    localparam int DW = tlsp_pkg::DEN_W;
    localparam int KW = $clog2(NW + 1);

    tlsp_pkg::t_back_state r_state, n_state;
    tlsp_pkg::t_sums       r_s;

    logic [17:0]            r_p1, r_p2;
    logic [29:0]            r_p3, r_p4;
    logic [NRW-1:0]         r_nr;
    logic signed [19:0]     r_d;
    logic signed [31:0]     r_sl;
    logic signed [TW-1:0]   r_t;
    logic signed [41:0]     r_m1;
    logic signed [31+TW:0]  r_m2;
    logic signed [DW-1:0]   r_den;
    logic [NW-1:0]          r_dvd;
    logic [DW-1:0]          r_dvs;
    logic [tlsp_pkg::REM_W-1:0] r_rem;
    logic [KW-1:0]          r_k;

    logic [RW-1:0]          w_r;
    logic signed [NW-1:0]   w_num0, w_num, w_twice;
    logic signed [DW-1:0]   w_den0, w_den;
    logic                   w_zero;
    logic [tlsp_pkg::REM_W-1:0] w_rsh;
    logic                   w_ge;

    assign w_r = (32'(i_radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(i_radius);

    always_comb begin
        if (r_d == '0) begin
            w_num0 = NW'(r_s.sval);
            w_den0 = DW'(r_s.cnt);
        end else begin
            w_num0 = NW'(r_m1) + NW'(r_m2);
            w_den0 = r_den;
        end
        w_num   = (w_den0 < 0) ? -w_num0 : w_num0;
        w_den   = (w_den0 < 0) ? -w_den0 : w_den0;
        w_twice = (w_num <<< 1) + NW'(w_den);
        w_zero  = (r_s.cnt == '0) || (w_twice < 0);
    end

    assign w_rsh = {r_rem[tlsp_pkg::REM_W-2:0], r_dvd[NW-1]};
    assign w_ge  = (w_rsh >= tlsp_pkg::REM_W'(r_dvs));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tlsp_pkg::B_IDLE: if (!i_q_empty) n_state = tlsp_pkg::B_MUL1;
            tlsp_pkg::B_MUL1: n_state = tlsp_pkg::B_MUL2;
            tlsp_pkg::B_MUL2: n_state = tlsp_pkg::B_MUL3;
            tlsp_pkg::B_MUL3: n_state = tlsp_pkg::B_PREP;
            tlsp_pkg::B_PREP: n_state = w_zero ? tlsp_pkg::B_DONE : tlsp_pkg::B_DIV;
            tlsp_pkg::B_DIV:  if (r_k == KW'(1)) n_state = tlsp_pkg::B_DONE;
            tlsp_pkg::B_DONE: if (!i_out_full) n_state = tlsp_pkg::B_IDLE;
            default:          n_state = tlsp_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_ctl.pop  = (r_state == tlsp_pkg::B_IDLE) && !i_q_empty;
        o_ctl.push = (r_state == tlsp_pkg::B_DONE) && !i_out_full;
        o_value    = (r_dvd > NW'(i_max_value)) ? i_max_value
                                                : tlsp_pkg::VAL_W'(r_dvd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlsp_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            tlsp_pkg::B_IDLE: begin
                r_s <= i_sums;
            end
            tlsp_pkg::B_MUL1: begin
                r_p1 <= 18'(r_s.cnt) * 18'(r_s.ssq);
                r_p2 <= 18'(r_s.spos) * 18'(r_s.spos);
                r_p3 <= 30'(r_s.cnt) * 30'(r_s.spv);
                r_p4 <= 30'(r_s.spos) * 30'(r_s.sval);
                r_nr <= NRW'(r_s.cnt) * NRW'(w_r);
            end
            tlsp_pkg::B_MUL2: begin
                r_d  <= $signed({2'b00, r_p1}) - $signed({2'b00, r_p2});
                r_sl <= $signed({2'b00, r_p3}) - $signed({2'b00, r_p4});
                r_t  <= $signed({2'b00, r_nr}) - $signed(TW'(r_s.spos));
            end
            tlsp_pkg::B_MUL3: begin
                r_m1  <= 42'($signed({1'b0, r_s.sval})) * 42'(r_d);
                r_m2  <= (32+TW)'(r_sl) * (32+TW)'(r_t);
                r_den <= DW'($signed({1'b0, r_s.cnt})) * DW'(r_d);
            end
            tlsp_pkg::B_PREP: begin
                r_dvd <= w_zero ? '0 : w_twice;
                r_dvs <= DW'(w_den) << 1;
                r_rem <= '0;
                r_k   <= KW'(NW);
            end
            tlsp_pkg::B_DIV: begin
                r_rem <= w_ge ? w_rsh - tlsp_pkg::REM_W'(r_dvs) : w_rsh;
                r_dvd <= {r_dvd[NW-2:0], w_ge};
                r_k   <= r_k - 1'b1;
            end
            tlsp_pkg::B_DONE: begin
            end
            default: begin
            end
        endcase
    end
endmodule

// ===== rtl/temporal_least_squares_pixel.sv =====
// Top level of the temporal least-squares pixel filter.
// Depends on tlsp_pkg, tlsp_fifo, tlsp_front and tlsp_back.
`timescale 1ns / 1ps
// Samples of one pixel arrive one beat per cycle, each with its window slot;
// the beat flagged last closes the window and produces one fitted value at
// the centre slot, rounded half up and clamped to 0..max_value. The front
// accumulates at one sample per cycle unless the window queue is full. The
// back end takes one window at a time through states MUL1, MUL2, MUL3 and
// PREP and its one-bit-per-cycle restoring divider (skipped when the result
// is known to be zero); up to two closed windows queue in front of it and
// two results behind it. While the window queue is full, input beats are held off.
// Write radius and max_value only while the block is idle.
module temporal_least_squares_pixel #(
    parameter int MAX_RADIUS  = tlsp_pkg::MAX_RADIUS_DEF,
    parameter int SAMPLE_BITS = tlsp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    output logic                       o_full,
    input  logic [tlsp_pkg::SMP_W-1:0] i_sample,
    input  logic [tlsp_pkg::POS_W-1:0] i_position,
    input  logic                       i_is_last,
    output logic                       o_empty,
    input  logic                       i_pop,
    output logic [tlsp_pkg::VAL_W-1:0] o_value,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [tlsp_pkg::VAL_W-1:0] i_cfg_wdata
);
    logic [tlsp_pkg::RAD_W-1:0] r_radius;
    logic [tlsp_pkg::VAL_W-1:0] r_max_value;

    tlsp_pkg::t_sums     w_snap, w_q_sums;
    logic                w_snap_push, w_q_empty, w_out_full;
    tlsp_pkg::t_back_ctl w_ctl;
    logic [tlsp_pkg::VAL_W-1:0] w_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= tlsp_pkg::RADIUS_RST;
            r_max_value <= tlsp_pkg::MAX_VALUE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tlsp_pkg::CFG_RADIUS:    r_radius    <= i_cfg_wdata[tlsp_pkg::RAD_W-1:0];
                tlsp_pkg::CFG_MAX_VALUE: r_max_value <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    tlsp_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (i_push && !o_full),
        .i_sample    (i_sample),
        .i_position  (i_position),
        .i_is_last   (i_is_last),
        .o_snap      (w_snap),
        .o_snap_push (w_snap_push)
    );

    tlsp_fifo #(.WIDTH($bits(tlsp_pkg::t_sums)), .DEPTH(2)) u_win_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_snap_push),
        .i_data  (w_snap),
        .i_pop   (w_ctl.pop),
        .o_data  (w_q_sums),
        .o_full  (o_full),
        .o_empty (w_q_empty)
    );

    tlsp_back #(.MAX_RADIUS(MAX_RADIUS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sums      (w_q_sums),
        .i_q_empty   (w_q_empty),
        .i_radius    (r_radius),
        .i_max_value (r_max_value),
        .i_out_full  (w_out_full),
        .o_ctl       (w_ctl),
        .o_value     (w_value)
    );

    tlsp_fifo #(.WIDTH(tlsp_pkg::VAL_W), .DEPTH(2)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_ctl.push),
        .i_data  (w_value),
        .i_pop   (i_pop),
        .o_data  (o_value),
        .o_full  (w_out_full),
        .o_empty (o_empty)
    );

`ifndef SYNTHESIS
    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.push |-> !w_out_full) else $error("result beat pushed into full queue");
    a_win_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_snap_push |-> !o_full) else $error("window pushed into full queue");
    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.pop |-> !w_q_empty) else $error("back end popped empty queue");
`endif
endmodule
